/* src/wfe_pkg.sv */
// Shared types, fixed-point constants and divisor helpers for the free Wilson eigenvalue block.
// No dependencies; wfe_lane, wfe_merge and the top level import this package.
package wfe_pkg;

	typedef struct packed {
		logic signed [15:0] mom_axis0;
		logic signed [15:0] mom_axis1;
		logic signed [15:0] mom_axis2;
		logic signed [15:0] mom_axis3;
	} in_t;

	typedef struct packed {
		logic [21:0] eig_real;
		logic [17:0] eig_imag;
	} out_t;

	localparam logic [32:0] TWO_PI_Q30  = 33'd6746518852;
	localparam logic [31:0] PI_Q30      = 32'd3373259426;
	localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
	localparam logic [30:0] Q30_ONE     = 31'd1073741824;
	localparam logic [13:0] RED_RECIP   = 14'd10430;
	localparam logic [21:0] REAL_MAX    = 22'h3FFFFF;
	localparam logic [17:0] IMAG_MAX    = 18'd131072;
	localparam logic [15:0] WILSON_R_RST = 16'd8192;

	localparam int SERIES_TERMS = 10;
	localparam int SQ_STEPS     = 18;
	localparam int LANE_LAT     = 4 + 3 * SERIES_TERMS + 2;
	localparam int MERGE_LAT    = 3 + SQ_STEPS + 1;

	function automatic int sin_div(input int k);
		return (2 * k) * (2 * k + 1);
	endfunction

	function automatic int cos_div(input int k);
		return (2 * k - 1) * (2 * k);
	endfunction

	function automatic logic signed [15:0] mom_of(input in_t d, input int idx);
		logic signed [15:0] m;
		case (idx)
			0: m = d.mom_axis0;
			1: m = d.mom_axis1;
			2: m = d.mom_axis2;
			default: m = d.mom_axis3;
		endcase
		return m;
	endfunction

endpackage

/* src/wfe_divc.sv */
// Pipelined divide by a constant: reciprocal multiply, then remainder correction.
// Two register stages. Depends on nothing beyond its parameter.
module wfe_divc #(
	parameter int DIV = 6
) (
	input  logic        clk,
	input  logic        en,
	input  logic [32:0] num,
	output logic [31:0] quo
);
	localparam logic [31:0] RECIP = 32'((64'd1 << 32) / DIV);
	localparam logic [41:0] D1 = 42'(DIV);
	localparam logic [41:0] D2 = 42'(2 * DIV);
	localparam logic [41:0] D3 = 42'(3 * DIV);

	logic [32:0] num_s1;
	logic [31:0] qe_s1;
	logic [41:0] rem;
	logic [1:0]  fix;
	logic [31:0] quo_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			num_s1 <= num;
			qe_s1  <= 32'((65'(num) * 65'(RECIP)) >> 32);
		end
	end

	assign rem = 42'(num_s1) - 42'(qe_s1) * D1;
	assign fix = 2'(rem >= D1) + 2'(rem >= D2) + 2'(rem >= D3);

	always_ff @(posedge clk) begin
		if (en) begin
			quo_s2 <= qe_s1 + 32'(fix);
		end
	end

	assign quo = quo_s2;
endmodule

/* src/wfe_lane.sv */
// One axis lane: angle reduction, pipelined Taylor sine/cosine, per-axis squares.
// Depends on wfe_pkg and wfe_divc.
module wfe_lane #(
	parameter int ANGLE_FRAC_BITS = 13
) (
	input  logic               clk,
	input  logic               en,
	input  logic signed [15:0] mom,
	output logic [30:0]        sin2,
	output logic [32:0]        rterm
);
	import wfe_pkg::*;

	localparam int SH = 30 - ANGLE_FRAC_BITS;

	function automatic logic [30:0] clamp_q30(input logic signed [35:0] v);
		logic [30:0] r;
		if (v < 0)
			r = '0;
		else if (v > 36'(Q30_ONE))
			r = Q30_ONE;
		else
			r = v[30:0];
		return r;
	endfunction

	logic [16:0] mag;
	logic [37:0] a_full;
	logic [37:0] a_s1;
	logic [5:0]  qe_s1;
	logic [37:0] rr;
	logic [32:0] r_s2;
	logic [31:0] af;
	logic [30:0] xf;
	logic        cnf;
	logic [30:0] x_s3;
	logic        cn_s3;
	logic [30:0] x_s4;
	logic [31:0] x2_s4;
	logic        cn_s4;

	assign mag    = mom[15] ? 17'(17'h10000 - {1'b0, mom}) : {1'b0, mom};
	assign a_full = 38'(mag) << SH;

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1  <= a_full;
			qe_s1 <= 6'((26'(a_full[37:26]) * 26'(RED_RECIP)) >> 20);
		end
	end

	assign rr = a_s1 - 38'(qe_s1) * 38'(TWO_PI_Q30);

	always_ff @(posedge clk) begin
		if (en) begin
			r_s2 <= (rr >= 38'(TWO_PI_Q30)) ? 33'(rr - 38'(TWO_PI_Q30)) : rr[32:0];
		end
	end

	always_comb begin
		af  = (r_s2 > 33'(PI_Q30)) ? 32'(TWO_PI_Q30 - r_s2) : r_s2[31:0];
		cnf = af > 32'(HALF_PI_Q30);
		xf  = cnf ? 31'(PI_Q30 - af) : af[30:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s3  <= xf;
			cn_s3 <= cnf;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s4  <= x_s3;
			cn_s4 <= cn_s3;
			x2_s4 <= 32'((62'(x_s3) * 62'(x_s3) + 62'(1 << 29)) >> 30);
		end
	end

	logic [31:0]        st_l [0:SERIES_TERMS];
	logic [31:0]        ct_l [0:SERIES_TERMS];
	logic signed [35:0] sa_l [0:SERIES_TERMS];
	logic signed [35:0] ca_l [0:SERIES_TERMS];
	logic [31:0]        x2_l [0:SERIES_TERMS];
	logic               cn_l [0:SERIES_TERMS];

	assign st_l[0] = 32'(x_s4);
	assign ct_l[0] = 32'(Q30_ONE);
	assign sa_l[0] = '0;
	assign ca_l[0] = '0;
	assign x2_l[0] = x2_s4;
	assign cn_l[0] = cn_s4;

	for (genvar k = 1; k <= SERIES_TERMS; k++) begin : g_term
		localparam bit NEG = ((k - 1) % 2) == 1;

		logic [32:0]        sv_s1;
		logic [32:0]        cv_s1;
		logic signed [35:0] sa_s1, sa_s2, sa_s3;
		logic signed [35:0] ca_s1, ca_s2, ca_s3;
		logic [31:0]        x2_s1, x2_s2, x2_s3;
		logic               cn_s1, cn_s2, cn_s3;

		always_ff @(posedge clk) begin
			if (en) begin
				sv_s1 <= 33'((64'(st_l[k-1]) * 64'(x2_l[k-1])) >> 30);
				cv_s1 <= 33'((64'(ct_l[k-1]) * 64'(x2_l[k-1])) >> 30);
				sa_s1 <= NEG ? sa_l[k-1] - $signed(36'(st_l[k-1]))
				             : sa_l[k-1] + $signed(36'(st_l[k-1]));
				ca_s1 <= NEG ? ca_l[k-1] - $signed(36'(ct_l[k-1]))
				             : ca_l[k-1] + $signed(36'(ct_l[k-1]));
				x2_s1 <= x2_l[k-1];
				cn_s1 <= cn_l[k-1];
				sa_s2 <= sa_s1;
				ca_s2 <= ca_s1;
				x2_s2 <= x2_s1;
				cn_s2 <= cn_s1;
				sa_s3 <= sa_s2;
				ca_s3 <= ca_s2;
				x2_s3 <= x2_s2;
				cn_s3 <= cn_s2;
			end
		end

		wfe_divc #(.DIV(sin_div(k))) u_sdiv (
			.clk (clk),
			.en  (en),
			.num (sv_s1),
			.quo (st_l[k])
		);

		wfe_divc #(.DIV(cos_div(k))) u_cdiv (
			.clk (clk),
			.en  (en),
			.num (cv_s1),
			.quo (ct_l[k])
		);

		assign sa_l[k] = sa_s3;
		assign ca_l[k] = ca_s3;
		assign x2_l[k] = x2_s3;
		assign cn_l[k] = cn_s3;
	end

	localparam bit LAST_NEG = (SERIES_TERMS % 2) == 1;

	logic [30:0] s_f1;
	logic [30:0] c_f1;
	logic        cn_f1;
	logic [30:0] sin2_f2;
	logic [32:0] rterm_f2;

	always_ff @(posedge clk) begin
		if (en) begin
			s_f1  <= clamp_q30(LAST_NEG ? sa_l[SERIES_TERMS] - $signed(36'(st_l[SERIES_TERMS]))
			                            : sa_l[SERIES_TERMS] + $signed(36'(st_l[SERIES_TERMS])));
			c_f1  <= clamp_q30(LAST_NEG ? ca_l[SERIES_TERMS] - $signed(36'(ct_l[SERIES_TERMS]))
			                            : ca_l[SERIES_TERMS] + $signed(36'(ct_l[SERIES_TERMS])));
			cn_f1 <= cn_l[SERIES_TERMS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sin2_f2  <= 31'((62'(s_f1) * 62'(s_f1) + 62'(1 << 29)) >> 30);
			rterm_f2 <= cn_f1 ? 33'({1'b0, 32'(Q30_ONE) + 32'(c_f1)} << 1)
			                  : 33'({1'b0, 32'(Q30_ONE) - 32'(c_f1)} << 1);
		end
	end

	assign sin2  = sin2_f2;
	assign rterm = rterm_f2;
endmodule

/* src/wfe_merge.sv */
// Merge stage: sums lane terms, scales by r with saturation, pipelined rounded square root.
// Depends on wfe_pkg.
module wfe_merge #(
	parameter int NUM_AXES = 4
) (
	input  logic          clk,
	input  logic          en,
	input  logic [15:0]   wilson_r,
	input  logic [30:0]   sin2  [NUM_AXES],
	input  logic [32:0]   rterm [NUM_AXES],
	output wfe_pkg::out_t res
);
	import wfe_pkg::*;

	logic [34:0] sr_sum;
	logic [32:0] ss_sum;
	logic [34:0] sr_s1;
	logic [32:0] ss_s1;
	logic [50:0] prod_s2;
	logic [32:0] ss_s2;
	logic [22:0] rnd;
	logic [21:0] er_s3;
	logic [35:0] v_s3;

	always_comb begin
		sr_sum = '0;
		ss_sum = '0;
		for (int i = 0; i < NUM_AXES; i++) begin
			sr_sum = sr_sum + 35'(rterm[i]);
			ss_sum = ss_sum + 33'(sin2[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sr_s1   <= sr_sum;
			ss_s1   <= ss_sum;
			prod_s2 <= 51'(sr_s1) * 51'(wilson_r);
			ss_s2   <= ss_s1;
		end
	end

	assign rnd = 23'((prod_s2 + 51'(1 << 27)) >> 28);

	always_ff @(posedge clk) begin
		if (en) begin
			er_s3 <= (rnd > 23'(REAL_MAX)) ? REAL_MAX : rnd[21:0];
			v_s3  <= {1'b0, ss_s2, 2'b00};
		end
	end

	logic [19:0] rem_l  [0:SQ_STEPS];
	logic [17:0] root_l [0:SQ_STEPS];
	logic [35:0] v_l    [0:SQ_STEPS];
	logic [21:0] er_l   [0:SQ_STEPS];

	assign rem_l[0]  = '0;
	assign root_l[0] = '0;
	assign v_l[0]    = v_s3;
	assign er_l[0]   = er_s3;

	for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sqrt
		logic [21:0] cand;
		logic [21:0] trial;
		logic [19:0] rem_s1;
		logic [17:0] root_s1;
		logic [35:0] v_s1;
		logic [21:0] er_s1;

		assign cand  = {rem_l[i], v_l[i][35:34]};
		assign trial = {2'b00, root_l[i], 2'b01};

		always_ff @(posedge clk) begin
			if (en) begin
				if (cand >= trial) begin
					rem_s1  <= 20'(cand - trial);
					root_s1 <= {root_l[i][16:0], 1'b1};
				end else begin
					rem_s1  <= cand[19:0];
					root_s1 <= {root_l[i][16:0], 1'b0};
				end
				v_s1  <= {v_l[i][33:0], 2'b00};
				er_s1 <= er_l[i];
			end
		end

		assign rem_l[i+1]  = rem_s1;
		assign root_l[i+1] = root_s1;
		assign v_l[i+1]    = v_s1;
		assign er_l[i+1]   = er_s1;
	end

	out_t res_s;

	always_ff @(posedge clk) begin
		if (en) begin
			res_s.eig_real <= er_l[SQ_STEPS];
			res_s.eig_imag <= root_l[SQ_STEPS]
				+ 18'(20'(rem_l[SQ_STEPS]) > 20'(root_l[SQ_STEPS]));
		end
	end

	assign res = res_s;
endmodule

/* src/wilson_free_eigenvalue_top.sv */
// Top level of the free Wilson eigenvalue block: lanes, merge, output skid, r register.
// Depends on wfe_pkg, wfe_lane, wfe_merge.
//
//  channel | direction | handshake            | beat
//  in      | sink      | in_valid / in_ready  | in_t, one momentum vector
//  out     | source    | out_valid/out_ready  | out_t, eig_real and eig_imag
//  cfg     | sink      | cfg_valid/cfg_ready  | 16-bit Wilson r
//
// One beat in per cycle while the skid register is empty; each beat taken passes the lane
// pipeline, then the merge and square root, then the output register.
// Reset clears the valid pipeline, output flags and r (to 0.5); no clearing pass.
// A stalled output fills the skid register, then the whole pipeline holds.
module wilson_free_eigenvalue_top #(
	parameter int ANGLE_FRAC_BITS = 13,
	parameter int NUM_AXES        = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  wfe_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output wfe_pkg::out_t out_data,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [15:0]   cfg_data
);
	import wfe_pkg::*;

	localparam int LAT = LANE_LAT + MERGE_LAT;

	logic          en;
	logic          skid_q;
	logic          out_valid_q;
	out_t          out_data_q;
	out_t          skid_data_q;
	logic [LAT-1:0] vld_q;
	logic [15:0]   wilson_r_q;
	logic [30:0]   sin2  [NUM_AXES];
	logic [32:0]   rterm [NUM_AXES];
	out_t          res;
	logic          pop;
	logic          push;

	assign en        = !skid_q;
	assign in_ready  = en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wilson_r_q <= WILSON_R_RST;
		end else if (cfg_valid) begin
			wilson_r_q <= cfg_data;
		end
	end

	for (genvar ax = 0; ax < NUM_AXES; ax++) begin : g_lane
		wfe_lane #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_lane (
			.clk   (clk),
			.en    (en),
			.mom   (mom_of(in_data, ax)),
			.sin2  (sin2[ax]),
			.rterm (rterm[ax])
		);
	end

	wfe_merge #(.NUM_AXES(NUM_AXES)) u_merge (
		.clk      (clk),
		.en       (en),
		.wilson_r (wilson_r_q),
		.sin2     (sin2),
		.rterm    (rterm),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], in_valid};
		end
	end

	assign pop  = out_valid_q && out_ready;
	assign push = en && vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_q      <= 1'b0;
		end else if (pop) begin
			if (skid_q) begin
				skid_q <= 1'b0;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			if (out_valid_q) begin
				skid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_data_q <= skid_q ? skid_data_q : res;
		end else if (push) begin
			if (out_valid_q) begin
				skid_data_q <= res;
			end else begin
				out_data_q <= res;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_q |-> out_valid_q)
		else $error("skid holds a beat while output register is empty");

	a_skid_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_q) |-> $past(out_valid_q && !out_ready))
		else $error("skid filled without an output stall");

	a_imag_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_data_q.eig_imag <= IMAG_MAX))
		else $error("eig_imag above 2.0");

	a_hold_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		skid_q && !out_ready |=> $stable(vld_q))
		else $error("pipeline advanced while skid full");
endmodule
